[src/rc_pkg.sv]
// shared types, constants and helper functions for the radix converter
// no dependencies; used by every module under src

package rc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 5;
  localparam int CHAR_W     = 7;

  // quotient bits retired per divider cycle
  localparam int STEP_BITS  = 4;
  localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS   = DIV_STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // digit stack holds one entry per possible digit (binary is the worst case)
  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int DEPTH_W    = $clog2(MAX_DIGITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(27);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_item_t;

  // request into the shared divider
  typedef struct packed {
    logic                  go;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  // control into the digit stack
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [DIGIT_W-1:0] din;
  } stk_ctrl_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

[src/radix_converter.sv]
// top level of the radix converter: sequencer, divider and digit stack
// depends on rc_pkg, rc_divider and rc_digit_stack

// A beat on the input (start high while busy is low) carries a value and a
// target base; a base below 2 is taken as 2 and one above 27 as 27. The block
// divides the value by the base again and again in one shared divider that
// retires STEP_BITS quotient bits a cycle, and the remainders go onto a digit
// stack. Once the quotient reaches zero the digits come out most significant
// first, one beat a cycle on out_strobe/out_item, the final one with last set.
// Busy stays high while the item is divided and its digits are emitted; a
// zero value gives a single digit '0'. The receiver cannot stall: every
// result beat is shown for exactly one cycle and must be taken then. A new
// item can be started in the cycle in which the final result beat is shown.

module radix_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rc_pkg::in_item_t   in_item,
  output logic               busy,
  output logic               out_strobe,
  output rc_pkg::out_item_t  out_item
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  rc_pkg::out_item_t               out_item_r, out_item_nxt;
  logic [rc_pkg::RADIX_W-1:0]      radix_r, radix_nxt;

  rc_pkg::div_req_t                div_req;
  rc_pkg::div_rsp_t                div_rsp;
  rc_pkg::stk_ctrl_t               stk_ctrl;
  logic [rc_pkg::DIGIT_W-1:0]      stk_top;
  logic [rc_pkg::DEPTH_W-1:0]      stk_count;

  logic                            accept;

  assign accept = start && (state_r == S_IDLE);

  // shared divide unit, one division per digit
  rc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // remainders collect here and leave in reverse order
  rc_digit_stack u_stk (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (stk_ctrl),
    .top   (stk_top),
    .count (stk_count)
  );

  always_comb begin
    state_nxt      = state_r;
    radix_nxt      = radix_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    div_req        = '0;
    div_req.divisor = radix_r;
    stk_ctrl       = '0;
    stk_ctrl.din   = div_rsp.remainder;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // launch the first division straight from the input beat
          radix_nxt        = rc_pkg::clamp_radix(in_item.radix);
          div_req.go       = 1'b1;
          div_req.dividend = in_item.value;
          div_req.divisor  = rc_pkg::clamp_radix(in_item.radix);
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          stk_ctrl.push = 1'b1;
          if (div_rsp.quotient == '0) begin
            state_nxt = S_EMIT;
          end else begin
            // keep dividing the quotient by the same base
            div_req.go       = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end
        end
      end
      S_EMIT: begin
        // one digit beat per cycle, most significant first
        stk_ctrl.pop            = 1'b1;
        out_strobe_nxt          = 1'b1;
        out_item_nxt.digit_char = rc_pkg::digit_to_ascii(stk_top);
        out_item_nxt.last       = (stk_count == rc_pkg::DEPTH_W'(1));
        if (stk_count == rc_pkg::DEPTH_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    radix_r    <= radix_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[src/rc_divider.sv]
// iterative restoring divider, STEP_BITS quotient bits per cycle
// depends on rc_pkg

module rc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rc_pkg::div_req_t  req,
  output rc_pkg::div_rsp_t  rsp
);

  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [rc_pkg::STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rc_pkg::PAD_BITS-1:0]     q_r, q_nxt;
  logic [rc_pkg::DIGIT_W-1:0]      rem_r, rem_nxt;
  logic [rc_pkg::RADIX_W-1:0]      div_r, div_nxt;

  logic [rc_pkg::PAD_BITS-1:0]     q_step;
  logic [rc_pkg::DIGIT_W-1:0]      rem_step;

  // one step: STEP_BITS shift/compare/subtract rounds on narrow values
  always_comb begin
    logic [rc_pkg::DIGIT_W:0] trial;
    trial    = '0;
    q_step   = q_r;
    rem_step = rem_r;
    for (int i = 0; i < rc_pkg::STEP_BITS; i++) begin
      trial  = {rem_step, q_step[rc_pkg::PAD_BITS-1]};
      q_step = {q_step[rc_pkg::PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial     = trial - {1'b0, div_r};
        q_step[0] = 1'b1;
      end
      rem_step = trial[rc_pkg::DIGIT_W-1:0];
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = rc_pkg::PAD_BITS'(req.dividend);
      rem_nxt = '0;
      div_nxt = req.divisor;
    end else if (run_r) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rc_pkg::STEP_CNT_W'(rc_pkg::DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r[rc_pkg::VALUE_BITS-1:0];
  assign rsp.remainder = rem_r;

endmodule

[src/rc_digit_stack.sv]
// last-in first-out digit store; digits arrive least significant first
// depends on rc_pkg

module rc_digit_stack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rc_pkg::stk_ctrl_t            ctrl,
  output logic [rc_pkg::DIGIT_W-1:0]   top,
  output logic [rc_pkg::DEPTH_W-1:0]   count
);

  logic [rc_pkg::DIGIT_W-1:0] stk_r [rc_pkg::MAX_DIGITS];
  logic [rc_pkg::DEPTH_W-1:0] cnt_r;

  // entry 0 is the top; push shifts down the line, pop shifts back up
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk_r[0] <= ctrl.din;
      for (int i = 1; i < rc_pkg::MAX_DIGITS; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < rc_pkg::MAX_DIGITS - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.push) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (ctrl.pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign top   = stk_r[0];
  assign count = cnt_r;

endmodule
